// ===== src/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg
// Widths, codes, reset values and shared helpers of the box collision
// response pipeline.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int COORD_BITS     = 32;
  localparam int WEIGHT_BITS    = 17;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_BITS       = 31;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_BITS-1:0] BOX_WIDTH_RESET   = 31'd65536;
  localparam logic [CFG_BITS-1:0] BOX_HEIGHT_RESET  = 31'd65536;
  localparam logic [CFG_BITS-1:0] EDGE_MARGIN_RESET = 31'd5243;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_MARGIN = 2'd2;

  typedef enum logic [1:0] {
    ZONE_MIN = 2'd0,
    ZONE_MID = 2'd1,
    ZONE_MAX = 2'd2
  } rcr_zone_t;

  // load enables of pipeline stages 2 to 5
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } rcr_stage_en_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (x < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return x[COORD_BITS-1:0];
  endfunction

  // lo and hi are the edge thresholds with the margin already applied
  function automatic rcr_zone_t classify(input logic signed [COORD_BITS+1:0] p,
                                         input logic signed [COORD_BITS+1:0] lo,
                                         input logic signed [COORD_BITS+1:0] hi);
    if (p > lo) begin
      return (p < hi) ? ZONE_MID : ZONE_MAX;
    end
    return ZONE_MIN;
  endfunction

endpackage

// ===== src/rcr_in_if.sv =====
// ----------------------------------------------------------------------------
// rcr_in_if
// Collision item channel: box centre and speed, contact point, partner speed
// and the two weights.
// ----------------------------------------------------------------------------
interface rcr_in_if
  import rcr_pkg::*;
();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  centre_x;
  logic signed [COORD_BITS-1:0]  centre_y;
  logic signed [COORD_BITS-1:0]  velocity_x;
  logic signed [COORD_BITS-1:0]  velocity_y;
  logic signed [COORD_BITS-1:0]  partner_vel_x;
  logic signed [COORD_BITS-1:0]  partner_vel_y;
  logic signed [COORD_BITS-1:0]  contact_x;
  logic signed [COORD_BITS-1:0]  contact_y;
  logic        [WEIGHT_BITS-1:0] mass_share;
  logic        [WEIGHT_BITS-1:0] sponge_weight;

  modport source (
    output valid, centre_x, centre_y, velocity_x, velocity_y,
           partner_vel_x, partner_vel_y, contact_x, contact_y,
           mass_share, sponge_weight,
    input  ready
  );

  modport sink (
    input  valid, centre_x, centre_y, velocity_x, velocity_y,
           partner_vel_x, partner_vel_y, contact_x, contact_y,
           mass_share, sponge_weight,
    output ready
  );

endinterface

// ===== src/rcr_out_if.sv =====
// ----------------------------------------------------------------------------
// rcr_out_if
// Response item channel: pushed-out centre, resulting speed and contact zones.
// ----------------------------------------------------------------------------
interface rcr_out_if
  import rcr_pkg::*;
();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] new_centre_x;
  logic signed [COORD_BITS-1:0] new_centre_y;
  logic signed [COORD_BITS-1:0] new_velocity_x;
  logic signed [COORD_BITS-1:0] new_velocity_y;
  logic        [1:0]            zone_x;
  logic        [1:0]            zone_y;

  modport source (
    output valid, new_centre_x, new_centre_y, new_velocity_x, new_velocity_y,
           zone_x, zone_y,
    input  ready
  );

  modport sink (
    input  valid, new_centre_x, new_centre_y, new_velocity_x, new_velocity_y,
           zone_x, zone_y,
    output ready
  );

endinterface

// ===== src/rcr_blend.sv =====
// ----------------------------------------------------------------------------
// rcr_blend
// One axis of the speed blend: mass-weighted mix of box and partner speed
// plus the sponge share of the spread, rounded to Q16.16 and saturated.
// Four register stages, loaded by the stage enables of the host pipeline.
// ----------------------------------------------------------------------------
module rcr_blend
  import rcr_pkg::*;
(
  input  logic                          clk,
  input  rcr_stage_en_t                 en,
  input  logic signed [COORD_BITS-1:0]  vel,
  input  logic signed [COORD_BITS-1:0]  partner_vel,
  input  logic        [WEIGHT_BITS-1:0] mass,
  input  logic        [WEIGHT_BITS-1:0] rest,
  input  logic        [WEIGHT_BITS-1:0] sponge,
  output logic signed [COORD_BITS-1:0]  blended_r
);

  localparam int PROD_BITS = COORD_BITS + WEIGHT_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int DS_BITS   = SUM_BITS + WEIGHT_BITS + 1;
  localparam int ACC_BITS  = DS_BITS - FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

  logic signed [WEIGHT_BITS:0]    mass_s;
  logic signed [WEIGHT_BITS:0]    rest_s;
  logic signed [WEIGHT_BITS:0]    sponge_s;

  logic signed [PROD_BITS-1:0]    vm_nxt, oq_nxt, vq_nxt;
  logic signed [PROD_BITS-1:0]    vm_r, oq_r, vq_r;
  logic        [WEIGHT_BITS-1:0]  sponge_a_r, sponge_b_r;
  logic signed [SUM_BITS-1:0]     vb_nxt, d_nxt;
  logic signed [SUM_BITS-1:0]     vb_b_r, d_r, vb_c_r;
  logic signed [DS_BITS-1:0]      ds_nxt, ds_r;
  logic signed [ACC_BITS-1:0]     acc_nxt;
  logic signed [COORD_BITS-1:0]   blended_nxt;

  assign mass_s   = $signed({1'b0, mass});
  assign rest_s   = $signed({1'b0, rest});
  assign sponge_s = $signed({1'b0, sponge_b_r});

  // products at scale 2^32
  assign vm_nxt = vel * mass_s;
  assign oq_nxt = partner_vel * rest_s;
  assign vq_nxt = vel * rest_s;

  assign vb_nxt = SUM_BITS'(vm_r) + SUM_BITS'(oq_r);
  assign d_nxt  = SUM_BITS'(oq_r) - SUM_BITS'(vq_r);

  assign ds_nxt = DS_BITS'(d_r) * DS_BITS'(sponge_s);

  // floor of the sponge term, then round half up to Q16.16
  assign acc_nxt = ACC_BITS'(vb_c_r) + $signed(ds_r[DS_BITS-1:FRAC_BITS]) + ROUND_HALF;
  assign blended_nxt = sat_coord(64'($signed(acc_nxt[ACC_BITS-1:FRAC_BITS])));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      vm_r       <= vm_nxt;
      oq_r       <= oq_nxt;
      vq_r       <= vq_nxt;
      sponge_a_r <= sponge;
    end
    if (en.s3) begin
      vb_b_r     <= vb_nxt;
      d_r        <= d_nxt;
      sponge_b_r <= sponge_a_r;
    end
    if (en.s4) begin
      vb_c_r <= vb_b_r;
      ds_r   <= ds_nxt;
    end
    if (en.s5) begin
      blended_r <= blended_nxt;
    end
  end

endmodule

// ===== src/rect_collision_response_core.sv =====
// ----------------------------------------------------------------------------
// rect_collision_response_core: box collision response, six register stages
// path: an accepted item is registered in stage 1 and leaves from the stage 6 output register
// throughput: one item per cycle while the output is ready; a full stage holds while the next cannot take it
// reset: synchronous rst_n empties the pipeline and loads default margin and box size
// ----------------------------------------------------------------------------
module rect_collision_response_core
  import rcr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  rcr_in_if.sink                    in_ch,
  rcr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_wdata
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] ncx;
    logic signed [COORD_BITS-1:0] ncy;
    rcr_zone_t                    zx;
    rcr_zone_t                    zy;
    logic                         push_x;
    logic                         pos_x;
    logic                         push_y;
    logic                         pos_y;
  } rcr_carry_t;

  // configuration
  logic [CFG_BITS-1:0] box_width_r, box_height_r, edge_margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r   <= BOX_WIDTH_RESET;
      box_height_r  <= BOX_HEIGHT_RESET;
      edge_margin_r <= EDGE_MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_WIDTH:   box_width_r   <= cfg_wdata;
        REG_BOX_HEIGHT:  box_height_r  <= cfg_wdata;
        REG_EDGE_MARGIN: edge_margin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [COORD_BITS:0]   half_w, half_h;
  logic signed [COORD_BITS+1:0] margin;

  assign half_w = $signed({3'b000, box_width_r[CFG_BITS-1:1]});
  assign half_h = $signed({3'b000, box_height_r[CFG_BITS-1:1]});
  assign margin = $signed({3'b000, edge_margin_r});

  // stage valids and stall chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  rcr_stage_en_t en;

  assign rdy6 = !v6_r || out_ch.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign en = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: register the item, weight clamp, box edges
  logic signed [COORD_BITS-1:0] cx1_r, cy1_r, vx1_r, vy1_r, ox1_r, oy1_r, px1_r, py1_r;
  logic [WEIGHT_BITS-1:0]       m_nxt, s_nxt, q_nxt, m1_r, s1_r, q1_r;
  logic signed [COORD_BITS:0]   left_nxt, right_nxt, top_nxt, bottom_nxt;
  logic signed [COORD_BITS:0]   left1_r, right1_r, top1_r, bottom1_r;

  assign m_nxt = (in_ch.mass_share > WEIGHT_ONE) ? WEIGHT_ONE : in_ch.mass_share;
  assign s_nxt = (in_ch.sponge_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_ch.sponge_weight;
  assign q_nxt = WEIGHT_ONE - m_nxt;

  assign left_nxt   = (COORD_BITS + 1)'(in_ch.centre_x) - half_w;
  assign right_nxt  = (COORD_BITS + 1)'(in_ch.centre_x) + half_w;
  assign top_nxt    = (COORD_BITS + 1)'(in_ch.centre_y) - half_h;
  assign bottom_nxt = (COORD_BITS + 1)'(in_ch.centre_y) + half_h;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cx1_r     <= in_ch.centre_x;
      cy1_r     <= in_ch.centre_y;
      vx1_r     <= in_ch.velocity_x;
      vy1_r     <= in_ch.velocity_y;
      ox1_r     <= in_ch.partner_vel_x;
      oy1_r     <= in_ch.partner_vel_y;
      px1_r     <= in_ch.contact_x;
      py1_r     <= in_ch.contact_y;
      m1_r      <= m_nxt;
      s1_r      <= s_nxt;
      q1_r      <= q_nxt;
      left1_r   <= left_nxt;
      right1_r  <= right_nxt;
      top1_r    <= top_nxt;
      bottom1_r <= bottom_nxt;
    end
  end

  // stage 2: zone classification against the margin thresholds
  logic signed [COORD_BITS-1:0] cx2_r, cy2_r, vx2_r, vy2_r, px2_r, py2_r;
  rcr_zone_t                    zx_nxt, zy_nxt, zx2_r, zy2_r;
  logic                         lt_x2_r, lt_y2_r;

  assign zx_nxt = classify((COORD_BITS + 2)'(px1_r),
                           (COORD_BITS + 2)'(left1_r) + margin,
                           (COORD_BITS + 2)'(right1_r) - margin);
  assign zy_nxt = classify((COORD_BITS + 2)'(py1_r),
                           (COORD_BITS + 2)'(top1_r) + margin,
                           (COORD_BITS + 2)'(bottom1_r) - margin);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      vx2_r   <= vx1_r;
      vy2_r   <= vy1_r;
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      zx2_r   <= zx_nxt;
      zy2_r   <= zy_nxt;
      lt_x2_r <= (px1_r < cx1_r);
      lt_y2_r <= (py1_r < cy1_r);
    end
  end

  // stage 3: push direction and pushed-out centre
  rcr_carry_t                 c3_nxt, c3_r, c4_r, c5_r;
  logic                       push_x, pos_x, push_y, pos_y;
  logic signed [COORD_BITS:0] push_cx, push_cy;

  always_comb begin
    push_x = 1'b0;
    pos_x  = 1'b0;
    push_y = 1'b0;
    pos_y  = 1'b0;
    if (zx2_r == ZONE_MID && zy2_r == ZONE_MID) begin
      push_x = 1'b1;
      pos_x  = lt_x2_r;
      push_y = 1'b1;
      pos_y  = lt_y2_r;
    end else if (zx2_r == ZONE_MID) begin
      push_y = 1'b1;
      pos_y  = (zy2_r == ZONE_MIN);
    end else if (zy2_r == ZONE_MID) begin
      push_x = 1'b1;
      pos_x  = (zx2_r == ZONE_MIN);
    end
  end

  // centre + (contact - edge) reduces to contact +/- half size
  assign push_cx = pos_x ? (COORD_BITS + 1)'(px2_r) + half_w
                         : (COORD_BITS + 1)'(px2_r) - half_w;
  assign push_cy = pos_y ? (COORD_BITS + 1)'(py2_r) + half_h
                         : (COORD_BITS + 1)'(py2_r) - half_h;

  always_comb begin
    c3_nxt.vx     = vx2_r;
    c3_nxt.vy     = vy2_r;
    c3_nxt.ncx    = push_x ? sat_coord(64'(push_cx)) : cx2_r;
    c3_nxt.ncy    = push_y ? sat_coord(64'(push_cy)) : cy2_r;
    c3_nxt.zx     = zx2_r;
    c3_nxt.zy     = zy2_r;
    c3_nxt.push_x = push_x;
    c3_nxt.pos_x  = pos_x;
    c3_nxt.push_y = push_y;
    c3_nxt.pos_y  = pos_y;
  end

  always_ff @(posedge clk) begin
    if (rdy3) c3_r <= c3_nxt;
    if (rdy4) c4_r <= c3_r;
    if (rdy5) c5_r <= c4_r;
  end

  // blended speeds, ready at the end of stage 5
  logic signed [COORD_BITS-1:0] bx5_r, by5_r;

  rcr_blend u_blend_x (
    .clk         (clk),
    .en          (en),
    .vel         (vx1_r),
    .partner_vel (ox1_r),
    .mass        (m1_r),
    .rest        (q1_r),
    .sponge      (s1_r),
    .blended_r   (bx5_r)
  );

  rcr_blend u_blend_y (
    .clk         (clk),
    .en          (en),
    .vel         (vy1_r),
    .partner_vel (oy1_r),
    .mass        (m1_r),
    .rest        (q1_r),
    .sponge      (s1_r),
    .blended_r   (by5_r)
  );

  // stage 6: speed clamp on pushed axes, output register
  logic signed [COORD_BITS-1:0] nvx_nxt, nvy_nxt;
  logic signed [COORD_BITS-1:0] ncx6_r, ncy6_r, nvx6_r, nvy6_r;
  rcr_zone_t                    zx6_r, zy6_r;

  always_comb begin
    nvx_nxt = c5_r.vx;
    nvy_nxt = c5_r.vy;
    if (c5_r.push_x) begin
      if (c5_r.pos_x) nvx_nxt = (bx5_r > c5_r.vx) ? bx5_r : c5_r.vx;
      else            nvx_nxt = (bx5_r < c5_r.vx) ? bx5_r : c5_r.vx;
    end
    if (c5_r.push_y) begin
      if (c5_r.pos_y) nvy_nxt = (by5_r > c5_r.vy) ? by5_r : c5_r.vy;
      else            nvy_nxt = (by5_r < c5_r.vy) ? by5_r : c5_r.vy;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      ncx6_r <= c5_r.ncx;
      ncy6_r <= c5_r.ncy;
      nvx6_r <= nvx_nxt;
      nvy6_r <= nvy_nxt;
      zx6_r  <= c5_r.zx;
      zy6_r  <= c5_r.zy;
    end
  end

  assign out_ch.valid          = v6_r;
  assign out_ch.new_centre_x   = ncx6_r;
  assign out_ch.new_centre_y   = ncy6_r;
  assign out_ch.new_velocity_x = nvx6_r;
  assign out_ch.new_velocity_y = nvy6_r;
  assign out_ch.zone_x         = zx6_r;
  assign out_ch.zone_y         = zy6_r;

  // an accepted item always lands in stage 1
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item missing from stage 1");

  // refusing input means stage 1 holds an item
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r)
    else $error("input stalled with stage 1 empty");

  // the x axis, when it is not pushed, keeps its speed
  assert property (@(posedge clk) disable iff (!rst_n)
    (rdy6 && v5_r && !c5_r.push_x) |=> (out_ch.new_velocity_x == $past(c5_r.vx)))
    else $error("unpushed x speed changed");

  // a corner contact pushes neither axis
  assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && c3_r.zx != ZONE_MID && c3_r.zy != ZONE_MID) |-> (!c3_r.push_x && !c3_r.push_y))
    else $error("corner contact pushed the box");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: box collision response core
// Walks a directed table of edge, middle and corner contacts under the reset
// box size. It then runs random contacts under a series of box sizes and
// margins, from zero to full scale. Every response is checked against a typed
// table entry or a local model of the zone test, speed blend and push-out.
// ----------------------------------------------------------------------------
module tb;
  import rcr_pkg::*;

  localparam int     STALL_LIMIT     = 4000;
  localparam int     N_PHASES        = 8;
  localparam int     ITEMS_PER_PHASE = 117;
  localparam longint COORD_MAX       = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN       = -COORD_MAX - 1;
  localparam longint Q_ONE           = longint'(WEIGHT_ONE);
  localparam longint Q_HALF          = Q_ONE >>> 1;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0]  centre_x;
    logic [COORD_BITS-1:0]  centre_y;
    logic [COORD_BITS-1:0]  velocity_x;
    logic [COORD_BITS-1:0]  velocity_y;
    logic [COORD_BITS-1:0]  partner_vel_x;
    logic [COORD_BITS-1:0]  partner_vel_y;
    logic [COORD_BITS-1:0]  contact_x;
    logic [COORD_BITS-1:0]  contact_y;
    logic [WEIGHT_BITS-1:0] mass_share;
    logic [WEIGHT_BITS-1:0] sponge_weight;
  } collision_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] new_centre_x;
    logic [COORD_BITS-1:0] new_centre_y;
    logic [COORD_BITS-1:0] new_velocity_x;
    logic [COORD_BITS-1:0] new_velocity_y;
    rcr_zone_t             zone_x;
    rcr_zone_t             zone_y;
  } response_t;

  typedef struct {
    collision_t hit;
    bit         typed;
    response_t  resp;
  } contact_row_t;

  localparam response_t NO_RESP = '0;

  logic clk;
  logic rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_wdata;

  rcr_in_if  in_ch ();
  rcr_out_if out_ch ();

  rect_collision_response_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [CFG_BITS-1:0] cur_width  = BOX_WIDTH_RESET;
  logic [CFG_BITS-1:0] cur_height = BOX_HEIGHT_RESET;
  logic [CFG_BITS-1:0] cur_margin = EDGE_MARGIN_RESET;

  response_t    pending_responses[$];
  contact_row_t contact_table[$];
  bit           gaps_on = 1'b1;
  int           collisions_sent = 0;
  int           responses_seen  = 0;
  int           mismatch_count  = 0;
  int           stall_cycles    = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint x);
    if (x > COORD_MAX) begin
      return COORD_MAX[COORD_BITS-1:0];
    end else if (x < COORD_MIN) begin
      return COORD_MIN[COORD_BITS-1:0];
    end
    return x[COORD_BITS-1:0];
  endfunction

  function automatic rcr_zone_t zone_of(longint p, longint lo, longint hi);
    if (p > lo) begin
      return (p < hi) ? ZONE_MID : ZONE_MAX;
    end
    return ZONE_MIN;
  endfunction

  // speed after mass and sponge blend, rounded half up to Q16.16
  function automatic longint weighted_speed(longint v, longint o, longint m, longint s);
    longint q, vb, d, dh, dl, acc;
    q   = Q_ONE - m;
    vb  = v * m + o * q;
    d   = (o - v) * q;
    dh  = d >>> FRAC_BITS;
    dl  = d - (dh <<< FRAC_BITS);
    acc = vb + dh * s + ((dl * s) >>> FRAC_BITS);
    return $signed(clamp_coord((acc + Q_HALF) >>> FRAC_BITS));
  endfunction

  function automatic response_t predict_response(collision_t c);
    longint    cx, cy, vx, vy, px, py, m, s, hw, hh, mg;
    longint    lft, rgt, top_e, bot_e, ncx, ncy, nvx, nvy, bx, by;
    rcr_zone_t zx, zy;
    bit        push_x, push_y, up_x, up_y;
    response_t r;
    cx = $signed(c.centre_x);
    cy = $signed(c.centre_y);
    vx = $signed(c.velocity_x);
    vy = $signed(c.velocity_y);
    px = $signed(c.contact_x);
    py = $signed(c.contact_y);
    m  = c.mass_share;
    s  = c.sponge_weight;
    if (m > Q_ONE) m = Q_ONE;
    if (s > Q_ONE) s = Q_ONE;
    hw = cur_width >> 1;
    hh = cur_height >> 1;
    mg = cur_margin;
    lft   = cx - hw;
    rgt   = cx + hw;
    top_e = cy - hh;
    bot_e = cy + hh;
    zx = zone_of(px, lft + mg, rgt - mg);
    zy = zone_of(py, top_e + mg, bot_e - mg);
    bx = weighted_speed(vx, $signed(c.partner_vel_x), m, s);
    by = weighted_speed(vy, $signed(c.partner_vel_y), m, s);
    ncx = cx;
    ncy = cy;
    nvx = vx;
    nvy = vy;
    push_x = 1'b0;
    push_y = 1'b0;
    up_x   = 1'b0;
    up_y   = 1'b0;
    if (zx == ZONE_MID && zy == ZONE_MID) begin
      push_x = 1'b1;
      up_x   = (px < cx);
      push_y = 1'b1;
      up_y   = (py < cy);
    end else if (zx == ZONE_MID) begin
      push_y = 1'b1;
      up_y   = (zy == ZONE_MIN);
    end else if (zy == ZONE_MID) begin
      push_x = 1'b1;
      up_x   = (zx == ZONE_MIN);
    end
    if (push_x) begin
      if (up_x) begin
        ncx = cx + (px - lft);
        nvx = (bx > vx) ? bx : vx;
      end else begin
        ncx = cx + (px - rgt);
        nvx = (bx < vx) ? bx : vx;
      end
    end
    if (push_y) begin
      if (up_y) begin
        ncy = cy + (py - top_e);
        nvy = (by > vy) ? by : vy;
      end else begin
        ncy = cy + (py - bot_e);
        nvy = (by < vy) ? by : vy;
      end
    end
    r.new_centre_x   = clamp_coord(ncx);
    r.new_centre_y   = clamp_coord(ncy);
    r.new_velocity_x = clamp_coord(nvx);
    r.new_velocity_y = clamp_coord(nvy);
    r.zone_x         = zx;
    r.zone_y         = zy;
    return r;
  endfunction

  function automatic collision_t mk(logic [31:0] cx, logic [31:0] cy, logic [31:0] vx,
                                    logic [31:0] vy, logic [31:0] ox, logic [31:0] oy,
                                    logic [31:0] px, logic [31:0] py,
                                    logic [16:0] m, logic [16:0] s);
    collision_t c;
    c = '{cx, cy, vx, vy, ox, oy, px, py, m, s};
    return c;
  endfunction

  // contact placed around the thresholds, inside the margins, in the middle, outside the box or anywhere
  function automatic logic [COORD_BITS-1:0] pick_contact(logic [COORD_BITS-1:0] centre,
                                                         logic [CFG_BITS-1:0] size);
    longint cc, hw, mg, span, j, p;
    cc   = $signed(centre);
    hw   = size >> 1;
    mg   = cur_margin;
    span = hw - mg;
    j    = longint'($urandom_range(2)) - 1;
    case ($urandom_range(9))
      0: p = cc - hw + mg + j;
      1: p = cc + hw - mg + j;
      2, 3: p = (span > 0) ? cc - span + (longint'($urandom) % (2 * span + 1)) : cc;
      4: p = cc - hw + (longint'($urandom) % (mg + 1));
      5: p = cc + hw - (longint'($urandom) % (mg + 1));
      6: p = cc - hw - longint'($urandom_range(65535));
      7: p = cc + hw + longint'($urandom_range(65535));
      8: p = $signed($urandom);
      default: p = cc + longint'($urandom_range(64)) - 32;
    endcase
    return clamp_coord(p);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_speed();
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return clamp_coord(longint'($urandom_range(1 << 21)) - (1 << 20));
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_centre();
    case ($urandom_range(7))
      0: return $urandom;
      1: return COORD_MAX[COORD_BITS-1:0];
      2: return COORD_MIN[COORD_BITS-1:0];
      default: return clamp_coord(longint'($urandom_range(1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return WEIGHT_ONE;
      2: return WEIGHT_BITS'($urandom_range(131071, 65537));
      default: return WEIGHT_BITS'($urandom_range(65536));
    endcase
  endfunction

  function automatic collision_t random_collision();
    collision_t c;
    c.centre_x      = pick_centre();
    c.centre_y      = pick_centre();
    c.velocity_x    = pick_speed();
    c.velocity_y    = pick_speed();
    c.partner_vel_x = pick_speed();
    c.partner_vel_y = pick_speed();
    c.contact_x     = pick_contact(c.centre_x, cur_width);
    c.contact_y     = pick_contact(c.centre_y, cur_height);
    c.mass_share    = pick_weight();
    c.sponge_weight = pick_weight();
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic drive_collision(collision_t c, bit typed, response_t typed_resp);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.centre_x      <= c.centre_x;
    in_ch.centre_y      <= c.centre_y;
    in_ch.velocity_x    <= c.velocity_x;
    in_ch.velocity_y    <= c.velocity_y;
    in_ch.partner_vel_x <= c.partner_vel_x;
    in_ch.partner_vel_y <= c.partner_vel_y;
    in_ch.contact_x     <= c.contact_x;
    in_ch.contact_y     <= c.contact_y;
    in_ch.mass_share    <= c.mass_share;
    in_ch.sponge_weight <= c.sponge_weight;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_responses.push_back(typed ? typed_resp : predict_response(c));
    collisions_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_BOX_WIDTH:   cur_width  = data;
      REG_BOX_HEIGHT:  cur_height = data;
      REG_EDGE_MARGIN: cur_margin = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_config(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h,
                              logic [CFG_BITS-1:0] mg);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_EDGE_MARGIN, mg);
    write_reg(REG_UNUSED, CFG_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
  end

  always @(posedge clk) begin : check_responses
    response_t got;
    response_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      responses_seen++;
      got.new_centre_x   = out_ch.new_centre_x;
      got.new_centre_y   = out_ch.new_centre_y;
      got.new_velocity_x = out_ch.new_velocity_x;
      got.new_velocity_y = out_ch.new_velocity_y;
      got.zone_x         = rcr_zone_t'(out_ch.zone_x);
      got.zone_y         = rcr_zone_t'(out_ch.zone_y);
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("response %0d with nothing pending: %h", responses_seen, got);
        end
      end else begin
        want = pending_responses.pop_front();
        if (got.new_centre_x !== want.new_centre_x || got.new_centre_y !== want.new_centre_y ||
            got.new_velocity_x !== want.new_velocity_x ||
            got.new_velocity_y !== want.new_velocity_y ||
            got.zone_x !== want.zone_x || got.zone_y !== want.zone_y) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("response %0d mismatch: expected c=(%h,%h) v=(%h,%h) zone=(%0d,%0d)",
                     responses_seen, want.new_centre_x, want.new_centre_y,
                     want.new_velocity_x, want.new_velocity_y, want.zone_x, want.zone_y);
            $display("                       actual c=(%h,%h) v=(%h,%h) zone=(%0d,%0d)",
                     got.new_centre_x, got.new_centre_y, got.new_velocity_x,
                     got.new_velocity_y, got.zone_x, got.zone_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [CFG_BITS-1:0] w, h, mg;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_BOX_WIDTH;
    cfg_wdata           = '0;
    out_ch.ready        = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.centre_x      = '0;
    in_ch.centre_y      = '0;
    in_ch.velocity_x    = '0;
    in_ch.velocity_y    = '0;
    in_ch.partner_vel_x = '0;
    in_ch.partner_vel_y = '0;
    in_ch.contact_x     = '0;
    in_ch.contact_y     = '0;
    in_ch.mass_share    = '0;
    in_ch.sponge_weight = '0;

    // reset box: thresholds sit at centre -/+ 27525
    // corners come back untouched, whatever the speeds and weights
    contact_table.push_back(contact_row_t'{
      mk(0, 0, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h80000000,
         32'h80000000, 32'h80000000, 17'd32768, 17'd65536), 1'b1,
      '{32'h0, 32'h0, 32'h00010000, 32'hFFFF0000, ZONE_MIN, ZONE_MIN}});
    contact_table.push_back(contact_row_t'{
      mk(0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0,
         32'h7FFFFFFF, 32'h7FFFFFFF, 17'h1FFFF, 17'h1FFFF), 1'b1,
      '{32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, ZONE_MAX, ZONE_MAX}});
    contact_table.push_back(contact_row_t'{
      mk(0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
         32'h80000000, 32'h7FFFFFFF, 17'd0, 17'd0), 1'b1,
      '{32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, ZONE_MIN, ZONE_MAX}});
    // full mass share keeps the speed, contact at the centre pushes both axes down
    contact_table.push_back(contact_row_t'{
      mk(0, 0, 32'h00012345, 32'hFFFEDCBB, 32'h40000000, 32'hC0000000,
         0, 0, 17'd65536, 17'd0), 1'b1,
      '{32'hFFFF8000, 32'hFFFF8000, 32'h00012345, 32'hFFFEDCBB, ZONE_MID, ZONE_MID}});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h10000, 32'h10000, 32'hFFFE0000,
      32'h30000, -1, -1, 17'd16384, 17'd40000), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h5000, -32'sd7000, 32'h20000,
      32'h40000, 100, -30000, 17'd30000, 17'd20000), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h5000, -32'sd7000, 32'h20000,
      -32'sd262144, 100, 30000, 17'd30000, 17'd20000), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, -32'sd90000, 32'h100, 32'h90000,
      0, -30000, 5, 17'd1000, 17'd60000), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h90000, 32'h100, -32'sd90000,
      0, 30000, 5, 17'd1000, 17'd60000), 1'b0, NO_RESP});
    // exactly on the thresholds, and one step inside
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h1234, 32'h5678, 32'h70000,
      32'h1, -27525, 0, 17'd12345, 17'd54321), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h1234, 32'h5678, -32'sd458752,
      32'h1, 27525, 0, 17'd12345, 17'd54321), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h1234, 32'h5678, 32'h70000,
      -32'sd458752, -27524, 27524, 17'd12345, 17'd54321), 1'b0, NO_RESP});
    // weights above one saturate to one, then zero mass share with zero and full sponge
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h30000, -32'sd196608, 32'h7FFF0000,
      32'h80010000, -5, 5, 17'h1FFFF, 17'h10001), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h30000, -32'sd196608, -32'sd65536,
      32'h50000, -5, 5, 17'd0, 17'd0), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(0, 0, 32'h30000, -32'sd196608, -32'sd65536,
      32'h50000, -5, 5, 17'd0, 17'd65536), 1'b0, NO_RESP});
    // half-step ties in the rounding, positive and negative
    contact_table.push_back(contact_row_t'{mk(0, 0, 3, -1, 0, 0, 0, -1,
      17'd32768, 17'd0), 1'b0, NO_RESP});
    // push-out past full scale saturates the centre
    contact_table.push_back(contact_row_t'{mk(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000,
      32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFE, 0, 17'd32768, 17'd32768), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(32'h80000000, 32'h80000000, 32'h80000000,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h80000001,
      17'd65535, 17'd1), 1'b0, NO_RESP});
    contact_table.push_back(contact_row_t'{mk(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
      32'h55555555, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'hFFFFFFF0, 32'h55555550,
      17'h0FFFF, 17'h1FFFF), 1'b0, NO_RESP});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (contact_table[i]) begin
      drive_collision(contact_table[i].hit, contact_table[i].typed, contact_table[i].resp);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          w = BOX_WIDTH_RESET; h = BOX_HEIGHT_RESET; mg = EDGE_MARGIN_RESET;
        end
        1: begin
          w = '0; h = '0; mg = '0;
        end
        2: begin
          w = '1; h = '1; mg = '1;
        end
        3: begin
          w = CFG_BITS'($urandom_range(1 << 18)); h = CFG_BITS'($urandom_range(1 << 18));
          mg = CFG_BITS'($urandom_range(1 << 12));
        end
        4: begin
          w = '1; h = CFG_BITS'(3); mg = '0;
        end
        5: begin
          w = CFG_BITS'(1); h = CFG_BITS'(5 * 65536); mg = EDGE_MARGIN_RESET;
        end
        6: begin
          w = CFG_BITS'($urandom); h = CFG_BITS'($urandom); mg = CFG_BITS'($urandom);
        end
        default: begin
          w = CFG_BITS'($urandom_range(1 << 22)); h = CFG_BITS'($urandom_range(1 << 22));
          mg = CFG_BITS'($urandom_range(1 << 16));
        end
      endcase
      apply_config(w, h, mg);
      // one setting runs with both sides always ready
      gaps_on = (ph != 3);
      repeat (ITEMS_PER_PHASE) drive_collision(random_collision(), 1'b0, NO_RESP);
      drain();
    end

    repeat (12) @(posedge clk);
    $display("tb: %0d collision items sent over the directed table and %0d box settings",
             collisions_sent, N_PHASES);
    $display("tb: %0d responses compared, %0d mismatches", responses_seen, mismatch_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
